// ----- hdl/i2c_master_memory_access_defines.svh -----
`ifndef I2C_MASTER_MEMORY_ACCESS_DEFINES_SVH
`define I2C_MASTER_MEMORY_ACCESS_DEFINES_SVH

// check that cons holds in the same cycle as ante
`define I2CMMA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check that cons holds in the cycle after ante
`define I2CMMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/i2cmma_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2cmma_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0]  HALF_PERIOD_RESET = 8'd5;
    localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd50;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_BYTE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_NONE    = 2'd0,
        STATUS_OK      = 2'd1,
        STATUS_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic {
        REG_HALF_PERIOD = 1'b0,
        REG_ACK_TIMEOUT = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_TX_LOW,
        PH_TX_HIGH,
        PH_ACK_WAIT,
        PH_WANT,
        PH_RX_LOW,
        PH_RX_HIGH,
        PH_MACK_LOW,
        PH_MACK_HIGH,
        PH_STOP_PRE,
        PH_STOP_A,
        PH_STOP_B
    } phase_t;

    typedef enum logic [2:0] {
        ST_DEV_W,
        ST_MEM_HI,
        ST_MEM_LO,
        ST_DATA,
        ST_DEV_R,
        ST_RX
    } stage_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  device_address;
        logic [15:0] memory_address;
        logic        wide_address;
        logic [15:0] byte_count;
        logic [7:0]  write_byte;
        logic        sda_sample;
    } step_in_t;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        busy_res;
        logic        byte_wanted;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        read_last;
        status_t     status;
    } step_res_t;

endpackage

`default_nettype wire

// ----- hdl/i2cmma_fsm.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2cmma_fsm
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    step_en,
    input  i2cmma_pkg::step_in_t   step_in,
    input  wire  [7:0]             half_period_ticks,
    input  wire  [15:0]            ack_timeout_ticks,
    output i2cmma_pkg::step_res_t  step_res
);
    import i2cmma_pkg::*;

    phase_t           phase_reg, phase_next;
    stage_t           stage_reg, stage_next;
    logic [CNT_W-1:0] tick_reg, tick_next;
    logic [3:0]       bit_reg, bit_next;
    logic [7:0]       shift_reg, shift_next;
    logic [15:0]      bytes_left_reg, bytes_left_next;
    logic [7:0]       dev_addr_reg, dev_addr_next;
    logic [15:0]      mem_addr_reg, mem_addr_next;
    logic             wide_reg, wide_next;
    logic             is_read_reg, is_read_next;
    logic [7:0]       pending_byte_reg, pending_byte_next;
    logic             pending_valid_reg, pending_valid_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             timed_out_reg, timed_out_next;

    logic [CNT_W-1:0] hp_lim;
    logic [CNT_W-1:0] ack_lim;
    logic [CNT_W-1:0] tick_inc;
    logic             hp_done;
    logic [CNT_W-1:0] tick_timed;
    logic [3:0]       bit_inc;
    logic [7:0]       shift_up;
    logic [7:0]       shift_rx;
    logic [15:0]      bytes_dec;
    logic [7:0]       tx_byte;
    logic             rd_valid;
    logic [7:0]       rd_data;
    logic             rd_last;
    status_t          status;

    always_comb
    begin
        hp_lim     = (half_period_ticks == 8'd0) ? CNT_W'(1) : CNT_W'(half_period_ticks);
        ack_lim    = CNT_W'(ack_timeout_ticks);
        tick_inc   = (tick_reg != CNT_MAX) ? tick_reg + CNT_W'(1) : tick_reg;
        hp_done    = (tick_inc >= hp_lim);
        tick_timed = hp_done ? '0 : tick_inc;
        bit_inc    = bit_reg + 4'd1;
        shift_up   = {shift_reg[6:0], 1'b0};
        shift_rx   = {shift_reg[6:0], step_in.sda_sample};
        bytes_dec  = bytes_left_reg - 16'd1;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        tick_next          = tick_reg;
        bit_next           = bit_reg;
        shift_next         = shift_reg;
        bytes_left_next    = bytes_left_reg;
        dev_addr_next      = dev_addr_reg;
        mem_addr_next      = mem_addr_reg;
        wide_next          = wide_reg;
        is_read_next       = is_read_reg;
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        timed_out_next     = timed_out_reg;
        tx_byte            = shift_reg;
        rd_valid           = 1'b0;
        rd_data            = 8'd0;
        rd_last            = 1'b0;
        status             = STATUS_NONE;

        case (step_in.opcode)
            OP_WRITE, OP_READ:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    dev_addr_next      = step_in.device_address;
                    mem_addr_next      = step_in.memory_address;
                    wide_next          = step_in.wide_address;
                    bytes_left_next    = step_in.byte_count;
                    is_read_next       = (step_in.opcode == OP_READ);
                    pending_valid_next = 1'b0;
                    timed_out_next     = 1'b0;
                    stage_next         = ST_DEV_W;
                    shift_next         = {step_in.device_address[7:1], 1'b0};
                    bit_next           = 4'd0;
                    tick_next          = '0;
                    scl_next           = 1'b1;
                    sda_next           = 1'b1;
                    phase_next         = PH_START_A;
                end
            end
            OP_BYTE:
            begin
                pending_byte_next  = step_in.write_byte;
                pending_valid_next = 1'b1;
            end
            default:
            begin
                case (phase_reg)
                    PH_START_A:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            sda_next   = 1'b0;
                            phase_next = PH_START_B;
                        end
                    end
                    PH_START_B:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b0;
                            bit_next   = 4'd0;
                            sda_next   = shift_reg[7];
                            phase_next = PH_TX_LOW;
                        end
                    end
                    PH_TX_LOW:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b1;
                            phase_next = (bit_reg >= 4'd8) ? PH_ACK_WAIT : PH_TX_HIGH;
                        end
                    end
                    PH_TX_HIGH:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            shift_next = shift_up;
                            sda_next   = (bit_inc >= 4'd8) ? 1'b1 : shift_up[7];
                            phase_next = PH_TX_LOW;
                        end
                    end
                    PH_ACK_WAIT:
                    begin
                        if (!step_in.sda_sample)
                        begin
                            // slave acked: pick the next byte or bus phase
                            tick_next = '0;
                            scl_next  = 1'b0;
                            case (stage_reg)
                                ST_DEV_W, ST_MEM_HI:
                                begin
                                    if (stage_reg == ST_DEV_W && wide_reg)
                                    begin
                                        stage_next = ST_MEM_HI;
                                        tx_byte    = mem_addr_reg[15:8];
                                    end
                                    else
                                    begin
                                        stage_next = ST_MEM_LO;
                                        tx_byte    = mem_addr_reg[7:0];
                                    end
                                    shift_next = tx_byte;
                                    bit_next   = 4'd0;
                                    sda_next   = tx_byte[7];
                                    phase_next = PH_TX_LOW;
                                end
                                ST_MEM_LO, ST_DATA:
                                begin
                                    if (stage_reg == ST_MEM_LO && is_read_reg)
                                    begin
                                        // repeated start for the read address
                                        stage_next = ST_DEV_R;
                                        shift_next = dev_addr_reg | 8'h01;
                                        sda_next   = 1'b1;
                                        scl_next   = 1'b1;
                                        phase_next = PH_START_A;
                                    end
                                    else
                                    begin
                                        stage_next = ST_DATA;
                                        if (stage_reg == ST_DATA)
                                        begin
                                            bytes_left_next = bytes_dec;
                                        end
                                        if ((stage_reg == ST_DATA ? bytes_dec : bytes_left_reg)
                                            == 16'd0)
                                        begin
                                            sda_next   = 1'b0;
                                            phase_next = PH_STOP_PRE;
                                        end
                                        else
                                        begin
                                            sda_next   = 1'b1;
                                            phase_next = PH_WANT;
                                        end
                                    end
                                end
                                ST_DEV_R:
                                begin
                                    stage_next = ST_RX;
                                    if (bytes_left_reg == 16'd0)
                                    begin
                                        sda_next   = 1'b0;
                                        phase_next = PH_STOP_PRE;
                                    end
                                    else
                                    begin
                                        sda_next   = 1'b1;
                                        bit_next   = 4'd0;
                                        shift_next = 8'd0;
                                        phase_next = PH_RX_LOW;
                                    end
                                end
                                default:
                                begin
                                    sda_next   = 1'b0;
                                    phase_next = PH_STOP_PRE;
                                end
                            endcase
                        end
                        else if (tick_reg >= ack_lim)
                        begin
                            timed_out_next = 1'b1;
                            scl_next       = 1'b0;
                            sda_next       = 1'b0;
                            tick_next      = '0;
                            phase_next     = PH_STOP_PRE;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_WANT:
                    begin
                        if (pending_valid_reg)
                        begin
                            shift_next         = pending_byte_reg;
                            pending_valid_next = 1'b0;
                            scl_next           = 1'b0;
                            bit_next           = 4'd0;
                            sda_next           = pending_byte_reg[7];
                            tick_next          = '0;
                            phase_next         = PH_TX_LOW;
                        end
                    end
                    PH_RX_LOW:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_RX_HIGH;
                        end
                    end
                    PH_RX_HIGH:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            shift_next = shift_rx;
                            scl_next   = 1'b0;
                            bit_next   = bit_inc;
                            if (bit_inc < 4'd8)
                            begin
                                phase_next = PH_RX_LOW;
                            end
                            else
                            begin
                                rd_valid        = 1'b1;
                                rd_data         = shift_rx;
                                rd_last         = (bytes_left_reg == 16'd1);
                                bytes_left_next = bytes_dec;
                                // ack unless this was the last byte
                                sda_next        = (bytes_dec == 16'd0);
                                phase_next      = PH_MACK_LOW;
                            end
                        end
                    end
                    PH_MACK_LOW:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_MACK_HIGH;
                        end
                    end
                    PH_MACK_HIGH:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next = 1'b0;
                            tick_next = '0;
                            if (bytes_left_reg != 16'd0)
                            begin
                                sda_next   = 1'b1;
                                bit_next   = 4'd0;
                                shift_next = 8'd0;
                                phase_next = PH_RX_LOW;
                            end
                            else
                            begin
                                sda_next   = 1'b0;
                                phase_next = PH_STOP_PRE;
                            end
                        end
                    end
                    PH_STOP_PRE:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            scl_next   = 1'b1;
                            phase_next = PH_STOP_A;
                        end
                    end
                    PH_STOP_A:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            sda_next   = 1'b1;
                            phase_next = PH_STOP_B;
                        end
                    end
                    PH_STOP_B:
                    begin
                        tick_next = tick_timed;
                        if (hp_done)
                        begin
                            phase_next = PH_IDLE;
                            status     = timed_out_reg ? STATUS_TIMEOUT : STATUS_OK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        scl_next   = 1'b1;
                        sda_next   = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        step_res.scl_level   = scl_next;
        step_res.sda_level   = sda_next;
        step_res.busy_res    = (phase_next != PH_IDLE);
        step_res.byte_wanted = (phase_next == PH_WANT) && !pending_valid_next;
        step_res.read_valid  = rd_valid;
        step_res.read_data   = rd_data;
        step_res.read_last   = rd_last;
        step_res.status      = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= ST_DEV_W;
            tick_reg          <= '0;
            bit_reg           <= 4'd0;
            shift_reg         <= 8'd0;
            bytes_left_reg    <= 16'd0;
            dev_addr_reg      <= 8'd0;
            mem_addr_reg      <= 16'd0;
            wide_reg          <= 1'b0;
            is_read_reg       <= 1'b0;
            pending_valid_reg <= 1'b0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
            timed_out_reg     <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            tick_reg          <= tick_next;
            bit_reg           <= bit_next;
            shift_reg         <= shift_next;
            bytes_left_reg    <= bytes_left_next;
            dev_addr_reg      <= dev_addr_next;
            mem_addr_reg      <= mem_addr_next;
            wide_reg          <= wide_next;
            is_read_reg       <= is_read_next;
            pending_valid_reg <= pending_valid_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
            timed_out_reg     <= timed_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            pending_byte_reg <= pending_byte_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/i2c_master_memory_access.sv -----
// I2C master for memory-style device access, advanced one transfer at a time.
// Input stream: each transfer is a command or a timing tick (s_tuser = opcode:
// tick, begin write, begin read, supply write byte). Only ticks move the bus.
// Output stream: exactly one result transfer per input transfer, carrying the
// driven SCL/SDA levels, busy, byte request, a received byte with m_tlast on
// the last byte of a read, and a one-shot status (ok or ack timeout) on the
// transfer that returns the block to idle.
// The result of a transfer is registered and appears in the cycle after it is accepted.
// Throughput: one transfer per cycle while the result register is free or being
// drained; the bus state machine update is combinational logic between the accepted input and the result register.
// A full result register that is not taken stalls the input (s_tready low)
// until m_tready frees it; nothing is dropped.
// Reset (rst_n low, asynchronous): bus idle with SCL and SDA released, no
// pending write byte, registers back to half period 5 and ack timeout 50.
// Registers on the APB port: 0x0 half_period_ticks, 0x4 ack_timeout_ticks;
// write them only while no transaction is running.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_master_memory_access_defines.svh"

module i2c_master_memory_access
(
    input  wire         clk,
    input  wire         rst_n,
    // apb configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    // device_address[7:0], memory_address[23:8], wide_address[24],
    // byte_count[40:25], write_byte[48:41], sda_sample[49], zero fill[55:50]
    input  wire  [55:0] s_tdata,
    // opcode[1:0]
    input  wire  [1:0]  s_tuser,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    // scl_level[0], sda_level[1], busy_res[2], byte_wanted[3], read_valid[4],
    // read_data[12:5], status[14:13], zero fill[15]
    output logic [15:0] m_tdata,
    // read_last
    output logic        m_tlast
);
    import i2cmma_pkg::*;

    logic [7:0]  half_period_reg;
    logic [15:0] ack_timeout_reg;
    logic        cfg_write;
    reg_index_t  cfg_index;

    step_in_t    step_in;
    step_res_t   step_res;
    logic        step_en;

    step_res_t   res_reg;
    logic        m_tvalid_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_timeout_reg <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= pwdata[7:0];
                REG_ACK_TIMEOUT: ack_timeout_reg <= pwdata[15:0];
                default:         half_period_reg <= half_period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_HALF_PERIOD: prdata = {24'd0, half_period_reg};
            REG_ACK_TIMEOUT: prdata = {16'd0, ack_timeout_reg};
            default:         prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        step_in.opcode         = opcode_t'(s_tuser);
        step_in.device_address = s_tdata[7:0];
        step_in.memory_address = s_tdata[23:8];
        step_in.wide_address   = s_tdata[24];
        step_in.byte_count     = s_tdata[40:25];
        step_in.write_byte     = s_tdata[48:41];
        step_in.sda_sample     = s_tdata[49];
    end

    // take a new transfer whenever the result slot is free or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step_en  = s_tvalid && s_tready;

    i2cmma_fsm u_fsm
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .step_en           (step_en),
        .step_in           (step_in),
        .half_period_ticks (half_period_reg),
        .ack_timeout_ticks (ack_timeout_reg),
        .step_res          (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (step_en)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = res_reg.read_last;
    assign m_tdata  = {1'b0, res_reg.status, res_reg.read_data, res_reg.read_valid,
                       res_reg.byte_wanted, res_reg.busy_res, res_reg.sda_level,
                       res_reg.scl_level};

    `I2CMMA_ASSERT_SAME(a_status_only_at_idle, clk, rst_n,
        m_tvalid_reg && (res_reg.status != STATUS_NONE), !res_reg.busy_res,
        "status reported while transaction still busy")
    `I2CMMA_ASSERT_SAME(a_read_byte_scl_low, clk, rst_n,
        m_tvalid_reg && res_reg.read_valid, !res_reg.scl_level && res_reg.busy_res,
        "received byte reported without scl low in a busy transaction")
    `I2CMMA_ASSERT_SAME(a_byte_wanted_holds_bus, clk, rst_n,
        m_tvalid_reg && res_reg.byte_wanted, !res_reg.scl_level && res_reg.busy_res,
        "byte request without scl held low")
    `I2CMMA_ASSERT_NEXT(a_stall_blocks_input, clk, rst_n,
        m_tvalid_reg && !m_tready && !step_en, m_tvalid_reg,
        "pending result lost while receiver stalled")

endmodule

`default_nettype wire
